@@ design/pnc_pkg.sv @@
// Shared types and constants for the palette nearest-color matcher.
// Used by the channel interfaces, the front and back parts and the top level.
`default_nettype none

package pnc_pkg;

  // Payload widths of the channels
  localparam int unsigned RGB_W  = 24;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned CODE_W = 2;
  // Largest Manhattan distance is 3 * 255 = 765
  localparam int unsigned DIST_W = 10;

  // Depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Request class after decode
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_FIND = 1'b1
  } op_e;

  // Result codes
  typedef enum logic [CODE_W-1:0] {
    RC_MATCH   = 2'd0,
    RC_ADDED   = 2'd1,
    RC_PRESENT = 2'd2,
    RC_FULL    = 2'd3
  } rc_e;

  // Command handed from front to back
  typedef struct packed {
    op_e              op;
    logic [RGB_W-1:0] color;
  } cmd_t;

  // Absolute difference of one color channel
  function automatic logic [CHAN_W-1:0] chan_absdiff(input logic [CHAN_W-1:0] a,
                                                     input logic [CHAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Sum of absolute R, G and B differences
  function automatic logic [DIST_W-1:0] rgb_distance(input logic [RGB_W-1:0] x,
                                                     input logic [RGB_W-1:0] y);
    logic [DIST_W-1:0] dr;
    logic [DIST_W-1:0] dg;
    logic [DIST_W-1:0] db;
    dr = DIST_W'(chan_absdiff(x[23:16], y[23:16]));
    dg = DIST_W'(chan_absdiff(x[15:8], y[15:8]));
    db = DIST_W'(chan_absdiff(x[7:0], y[7:0]));
    return dr + dg + db;
  endfunction

endpackage

`default_nettype wire

@@ design/pnc_req_if.sv @@
// Request channel: valid/ready handshake carrying request type and color.
// Depends on pnc_pkg for payload widths.
`default_nettype none

interface pnc_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [pnc_pkg::RGB_W-1:0]   rgb_color;

  modport source (output valid, output req_type, output rgb_color, input ready);
  modport sink   (input valid, input req_type, input rgb_color, output ready);
endinterface

`default_nettype wire

@@ design/pnc_rsp_if.sv @@
// Response channel: valid/ready handshake carrying palette index and result code.
// Depends on pnc_pkg for payload widths.
`default_nettype none

interface pnc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pnc_pkg::IDX_W-1:0]   palette_index;
  logic [pnc_pkg::CODE_W-1:0]  result_code;

  modport source (output valid, output palette_index, output result_code, input ready);
  modport sink   (input valid, input palette_index, input result_code, output ready);
endinterface

`default_nettype wire

@@ design/pnc_front.sv @@
// Front part: accepts requests, decodes them into commands and queues them.
// Depends on pnc_pkg and pnc_req_if.
`default_nettype none

module pnc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  pnc_req_if.sink            req,
  output logic               cmd_valid_o,
  output pnc_pkg::cmd_t      cmd_o,
  input  wire logic          cmd_ready_i
);

  localparam int unsigned PW = $clog2(pnc_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(pnc_pkg::QUEUE_DEPTH + 1);

  pnc_pkg::cmd_t slots_q [pnc_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] fill_q, fill_d;
  logic          push, pop;
  pnc_pkg::cmd_t cmd_in;

  // Classify the incoming request
  always_comb begin
    cmd_in.op    = req.req_type ? pnc_pkg::OP_FIND : pnc_pkg::OP_ADD;
    cmd_in.color = req.rgb_color;
  end

  assign req.ready   = (fill_q != CW'(pnc_pkg::QUEUE_DEPTH));
  assign push        = req.valid && req.ready;
  assign cmd_valid_o = (fill_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = slots_q[rd_ptr_q];

  // Pointer and fill update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(pnc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(pnc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

@@ design/pnc_back.sv @@
// Back part: palette memory, fill count, one-entry-per-cycle scan and result register.
// Depends on pnc_pkg and pnc_rsp_if.
`default_nettype none

module pnc_back #(
  parameter int unsigned PALETTE_DEPTH = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  pnc_pkg::cmd_t      cmd_i,
  output logic               cmd_ready_o,
  pnc_rsp_if.source          rsp
);

  localparam int unsigned IW = $clog2(PALETTE_DEPTH);
  localparam int unsigned CW = $clog2(PALETTE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(PALETTE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(PALETTE_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic [pnc_pkg::RGB_W-1:0]  mem [PALETTE_DEPTH];
  logic [CW-1:0]              count_q;
  pnc_pkg::op_e               op_q;
  logic [pnc_pkg::RGB_W-1:0]  color_q;
  logic [IW-1:0]              addr_q;
  logic                       issue_q;
  logic                       rd_vld_q;
  logic [IW-1:0]              rd_idx_q;
  logic [pnc_pkg::RGB_W-1:0]  rd_data_q;
  logic                       found_q;
  logic [pnc_pkg::DIST_W-1:0] best_q;
  logic [IW-1:0]              best_idx_q;
  logic [IW-1:0]              res_idx_q;
  pnc_pkg::rc_e               res_code_q;
  logic                       out_valid_q;
  logic [pnc_pkg::IDX_W-1:0]  out_idx_q;
  pnc_pkg::rc_e               out_code_q;

  logic                       accept, start_full, load_out;
  logic [pnc_pkg::RGB_W-1:0]  entry;
  logic [pnc_pkg::DIST_W-1:0] entry_dist;
  logic                       hit_eq, take_find, is_last, mem_we;
  logic [IW-1:0]              fin_idx;
  pnc_pkg::rc_e               fin_code;
  logic [IW+3:0]              idx_ext;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign accept      = cmd_valid_i && cmd_ready_o;
  assign start_full  = (cmd_i.op == pnc_pkg::OP_ADD) && (count_q >= FULL_CNT);
  assign load_out    = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

  // Compare stage: slots past the fill count still read as black
  assign entry      = (CW'(rd_idx_q) < count_q) ? rd_data_q : '0;
  assign entry_dist = pnc_pkg::rgb_distance(entry, color_q);
  assign hit_eq     = (entry == color_q);
  assign take_find  = (rd_idx_q == '0) || (entry_dist < best_q);
  assign is_last    = rd_vld_q && (rd_idx_q == LAST_IDX);
  assign mem_we     = is_last && (op_q == pnc_pkg::OP_ADD) && !found_q && !hit_eq;

  // Final result at the last compared entry
  always_comb begin
    if (op_q == pnc_pkg::OP_FIND) begin
      fin_idx  = take_find ? rd_idx_q : best_idx_q;
      fin_code = pnc_pkg::RC_MATCH;
    end else if (found_q) begin
      fin_idx  = best_idx_q;
      fin_code = pnc_pkg::RC_PRESENT;
    end else if (hit_eq) begin
      fin_idx  = rd_idx_q;
      fin_code = pnc_pkg::RC_PRESENT;
    end else begin
      fin_idx  = count_q[IW-1:0];
      fin_code = pnc_pkg::RC_ADDED;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = start_full ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (is_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue_q;
      if (accept) begin
        issue_q <= !start_full;
        found_q <= 1'b0;
      end else if (issue_q && (addr_q == LAST_IDX)) begin
        issue_q <= 1'b0;
      end
      if (rd_vld_q && (op_q == pnc_pkg::OP_ADD) && hit_eq) begin
        found_q <= 1'b1;
      end
      if (mem_we) begin
        count_q <= count_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= cmd_i.op;
      color_q    <= cmd_i.color;
      addr_q     <= '0;
      res_idx_q  <= '0;
      res_code_q <= pnc_pkg::RC_FULL;
    end else if (issue_q) begin
      addr_q <= addr_q + 1'b1;
    end
    rd_idx_q <= addr_q;
    if (rd_vld_q) begin
      if (op_q == pnc_pkg::OP_FIND) begin
        if (take_find) begin
          best_q     <= entry_dist;
          best_idx_q <= rd_idx_q;
        end
      end else if (!found_q && hit_eq) begin
        best_idx_q <= rd_idx_q;
      end
    end
    if (is_last) begin
      res_idx_q  <= fin_idx;
      res_code_q <= fin_code;
    end
    if (load_out) begin
      out_idx_q  <= idx_ext[pnc_pkg::IDX_W-1:0];
      out_code_q <= res_code_q;
    end
  end

  // Palette memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[IW-1:0]] <= color_q;
    end
    rd_data_q <= mem[addr_q];
  end

  assign idx_ext = {4'b0000, res_idx_q};

  assign rsp.valid         = out_valid_q;
  assign rsp.palette_index = out_idx_q;
  assign rsp.result_code   = out_code_q;

endmodule

`default_nettype wire

@@ design/palette_nearest_color_matcher.sv @@
// Palette nearest-color matcher: front queue, back scanner over the palette memory.
// A request passes through the front queue, the back scanner and the result and output
// registers; an add to a full palette skips the scan. The back takes a new command only
// after the last result is loaded into its output register, while the front queue holds
// up to two more requests. The scan reads one palette entry per cycle from its single read port.
// Reset: asynchronous, active low; palette reads as black and the fill count is zero.
`default_nettype none

module palette_nearest_color_matcher #(
  parameter int unsigned PALETTE_DEPTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pnc_req_if.sink    req_i,
  pnc_rsp_if.source  rsp_o
);

  logic          cmd_valid;
  logic          cmd_ready;
  pnc_pkg::cmd_t cmd;

  // Request decode and queue
  pnc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  // Palette store and scan
  pnc_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .rsp         (rsp_o)
  );

endmodule

`default_nettype wire

@@ tb/sv/palette_nearest_color_matcher_tb.sv @@
// Self-checking testbench for palette_nearest_color_matcher: drives add/find requests
// under several idle/stall patterns and checks every result against a palette tracker.
// Depends on pnc_pkg, pnc_req_if, pnc_rsp_if and the matcher RTL.
`timescale 1ns / 1ps
`default_nettype none

module palette_nearest_color_matcher_tb;

  localparam int unsigned PAL_DEPTH    = 16;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SETTLE_WAIT  = 3 * (PAL_DEPTH + 4);
  localparam int unsigned PHASE_ITEMS  = 470;
  localparam int unsigned ADD_PCT      = 6;

  typedef struct {
    logic [pnc_pkg::IDX_W-1:0] palette_index;
    pnc_pkg::rc_e              code;
  } palette_result_t;

  // Tracks the palette contents and the results still owed by the block
  class palette_tracker;
    logic [pnc_pkg::RGB_W-1:0] palette [PAL_DEPTH];
    int unsigned               fill_count;
    palette_result_t           owed_results [$];
    int unsigned               mismatches;

    function new();
      foreach (palette[i]) palette[i] = '0;
      fill_count = 0;
      mismatches = 0;
    endfunction

    static function int unsigned manhattan(logic [pnc_pkg::RGB_W-1:0] a,
                                           logic [pnc_pkg::RGB_W-1:0] b);
      int unsigned sum;
      sum = 0;
      for (int c = 0; c < 3; c++) begin
        if (a[c*8 +: 8] > b[c*8 +: 8]) sum += a[c*8 +: 8] - b[c*8 +: 8];
        else sum += b[c*8 +: 8] - a[c*8 +: 8];
      end
      return sum;
    endfunction

    // Apply one request to the tracked palette and return its outcome
    function palette_result_t apply_request(pnc_pkg::op_e op,
                                            logic [pnc_pkg::RGB_W-1:0] color);
      palette_result_t r;
      int unsigned     best;
      int unsigned     d;
      bit              found;
      r.palette_index = '0;
      found = 1'b0;
      if (op == pnc_pkg::OP_FIND) begin
        best = manhattan(palette[0], color);
        for (int i = 1; i < PAL_DEPTH; i++) begin
          d = manhattan(palette[i], color);
          // strict compare keeps the lowest index on a tie
          if (d < best) begin
            best = d;
            r.palette_index = pnc_pkg::IDX_W'(i);
          end
        end
        r.code = pnc_pkg::RC_MATCH;
      end else if (fill_count >= PAL_DEPTH) begin
        // full check wins even when the color is present
        r.code = pnc_pkg::RC_FULL;
      end else begin
        // unfilled slots still hold black and take part in the search
        for (int i = 0; i < PAL_DEPTH; i++) begin
          if (!found && palette[i] == color) begin
            found = 1'b1;
            r.palette_index = pnc_pkg::IDX_W'(i);
          end
        end
        if (found) begin
          r.code = pnc_pkg::RC_PRESENT;
        end else begin
          palette[fill_count] = color;
          r.palette_index = pnc_pkg::IDX_W'(fill_count);
          fill_count++;
          r.code = pnc_pkg::RC_ADDED;
        end
      end
      return r;
    endfunction

    function void note_request(pnc_pkg::op_e op, logic [pnc_pkg::RGB_W-1:0] color);
      owed_results.push_back(apply_request(op, color));
    endfunction

    function void check_result(logic [pnc_pkg::IDX_W-1:0] idx,
                               logic [pnc_pkg::CODE_W-1:0] code);
      palette_result_t want;
      if (owed_results.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result idx %0d code %0d", $realtime, idx, code);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      if (idx !== want.palette_index || code !== want.code) begin
        if (mismatches < 10)
          $display("%0t: mismatch: expected idx %0d code %s, got idx %0d code %0d",
                   $realtime, want.palette_index, want.code.name(), idx, code);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return owed_results.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pnc_req_if req_bus ();
  pnc_rsp_if rsp_bus ();

  palette_nearest_color_matcher #(
    .PALETTE_DEPTH(PAL_DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  palette_tracker palette_sb;
  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  int unsigned    cycle_count;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[palette_nearest_color_matcher] ERROR");
    $finish;
  end

  // Result side: check each transfer, then pick next ready
  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_bus.valid && rsp_bus.ready)
        palette_sb.check_result(rsp_bus.palette_index, rsp_bus.result_code);
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One request transfer; valid stays high unless an idle cycle is drawn
  task automatic send_request(input pnc_pkg::op_e op,
                              input logic [pnc_pkg::RGB_W-1:0] color);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid     <= 1'b1;
    req_bus.req_type  <= op;
    req_bus.rgb_color <= color;
    do @(posedge clk_i); while (!req_bus.ready);
    palette_sb.note_request(op, color);
  endtask

  // Hold off until every owed result has come back
  task automatic drain_results();
    req_bus.valid <= 1'b0;
    while (palette_sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  // Mostly finds near the stored colors; adds are sparse so the palette fills gradually
  task automatic send_random_batch(input int unsigned count);
    logic [pnc_pkg::RGB_W-1:0] color;
    pnc_pkg::op_e              op;
    int unsigned               sel;
    for (int n = 0; n < count; n++) begin
      color = palette_sb.palette[$urandom_range(PAL_DEPTH - 1)];
      if ($urandom_range(99) < ADD_PCT) begin
        op = pnc_pkg::OP_ADD;
        if ($urandom_range(9) < 6) color = pnc_pkg::RGB_W'($urandom);
      end else begin
        op  = pnc_pkg::OP_FIND;
        sel = $urandom_range(9);
        if (sel < 4) color = pnc_pkg::RGB_W'($urandom);
        else if (sel < 7) color = color ^ pnc_pkg::RGB_W'($urandom & 32'h0003_0303);
        else if (sel == 7) color = color ^ pnc_pkg::RGB_W'($urandom & 32'h001F_1F1F);
      end
      send_request(op, color);
    end
  endtask

  initial begin
    palette_sb     = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    req_bus.valid     <= 1'b0;
    req_bus.req_type  <= pnc_pkg::OP_ADD;
    req_bus.rgb_color <= '0;
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty palette, black already present, ties, channel extremes
    send_request(pnc_pkg::OP_FIND, 24'h000000);
    send_request(pnc_pkg::OP_FIND, 24'hFFFFFF);
    send_request(pnc_pkg::OP_ADD,  24'h000000);
    send_request(pnc_pkg::OP_ADD,  24'hFFFFFF);
    send_request(pnc_pkg::OP_ADD,  24'h000000);
    send_request(pnc_pkg::OP_ADD,  24'hFFFFFF);
    send_request(pnc_pkg::OP_ADD,  24'hFF0000);
    send_request(pnc_pkg::OP_ADD,  24'h00FF00);
    send_request(pnc_pkg::OP_ADD,  24'h0000FF);
    send_request(pnc_pkg::OP_FIND, 24'h000000);
    send_request(pnc_pkg::OP_FIND, 24'h7F7F7F);
    send_request(pnc_pkg::OP_FIND, 24'h808080);
    send_request(pnc_pkg::OP_FIND, 24'h800000);
    send_request(pnc_pkg::OP_FIND, 24'hFF00FF);
    send_request(pnc_pkg::OP_FIND, 24'h00FFFF);
    send_request(pnc_pkg::OP_ADD,  24'h000001);
    send_request(pnc_pkg::OP_FIND, 24'h000001);
    send_request(pnc_pkg::OP_ADD,  24'h800000);
    send_request(pnc_pkg::OP_FIND, 24'hC00000);
    send_request(pnc_pkg::OP_FIND, 24'h400000);
    drain_results();

    // Random phases: no idling, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      send_random_batch(PHASE_ITEMS);
      drain_results();
    end

    // Table is full by now: adds of fresh and present colors both report full
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(pnc_pkg::OP_ADD,  palette_sb.palette[3]);
    send_request(pnc_pkg::OP_ADD,  24'h000000);
    send_request(pnc_pkg::OP_ADD,  24'h123456);
    send_request(pnc_pkg::OP_FIND, 24'hFFFFFF);
    drain_results();

    if (palette_sb.mismatches == 0 && palette_sb.outstanding() == 0) begin
      $display("[palette_nearest_color_matcher] OK");
    end else begin
      $display("[palette_nearest_color_matcher] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
design/pnc_pkg.sv
design/pnc_req_if.sv
design/pnc_rsp_if.sv
design/pnc_front.sv
design/pnc_back.sv
design/palette_nearest_color_matcher.sv
tb/sv/palette_nearest_color_matcher_tb.sv
